// ===== rtl/ihex_pkg.sv =====
`default_nettype none
package ihex_pkg;

  localparam int CHAR_W  = 8;
  localparam int KIND_W  = 2;
  localparam int WADDR_W = 16;
  localparam int WDATA_W = 8;
  localparam int FLASH_W = 17;
  // start address plus byte index stays below 2^17
  localparam int SUM_W   = 17;

  localparam logic [CHAR_W-1:0]  CHAR_COLON   = 8'h3A;
  localparam logic [CHAR_W-1:0]  CHAR_NEWLINE = 8'h0A;
  localparam logic [FLASH_W-1:0] FLASH_RESET  = 17'h10000;
  localparam logic [7:0]         TYPE_EOF     = 8'h01;

  typedef enum logic [KIND_W-1:0] {
    KIND_WRITE     = 2'd0,
    KIND_END       = 2'd1,
    KIND_TOO_LONG  = 2'd2,
    KIND_OUT_RANGE = 2'd3
  } kind_t;

  // one classified character
  typedef struct packed {
    logic       is_newline;
    logic       is_colon;
    logic [3:0] nibble;
  } char_class_t;

  // handshake between the front and the back
  typedef struct packed {
    logic        valid;
    char_class_t item;
  } front_out_t;

  typedef struct packed {
    kind_t               kind;
    logic [WADDR_W-1:0]  write_address;
    logic [WDATA_W-1:0]  write_data;
  } result_t;

  // A-F and a-f give 10-15, any other character its low four bits
  function automatic char_class_t classify(input logic [CHAR_W-1:0] c);
    char_class_t r;
    logic        is_hex_letter;
    is_hex_letter = ((c >= 8'h41) && (c <= 8'h46)) || ((c >= 8'h61) && (c <= 8'h66));
    r.is_newline  = (c == CHAR_NEWLINE);
    r.is_colon    = (c == CHAR_COLON);
    r.nibble      = is_hex_letter ? (c[3:0] + 4'd9) : c[3:0];
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/ihex_front.sv =====
`default_nettype none
module ihex_front
  import ihex_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_push,
  output logic                   in_full,
  input  wire logic [CHAR_W-1:0] in_text_char,
  output front_out_t             front_out,
  input  wire logic              front_take
);

  // two-entry queue of classified characters
  char_class_t q_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  count_r, count_nxt;
  logic        push, pop;

  assign in_full = (count_r == 2'd2);
  assign push    = in_push && !in_full;
  assign pop     = front_take && (count_r != 2'd0);

  assign front_out.valid = (count_r != 2'd0);
  assign front_out.item  = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= classify(in_text_char);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ihex_back.sv =====
`default_nettype none
module ihex_back
  import ihex_pkg::*;
#(
  parameter int MAX_RECORD_BYTES = 16,
  parameter int ADDRESS_BITS     = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_valid,
  input  wire logic [FLASH_W-1:0] cfg_flash_bytes,
  input  wire front_out_t         front_out,
  output logic                    front_take,
  output logic                    out_empty,
  input  wire logic               out_pop,
  output result_t                 out_result
);

  localparam int LEN_W = $clog2(MAX_RECORD_BYTES + 1);
  localparam logic [WADDR_W-1:0] ADDR_MASK =
    WADDR_W'((32'd1 << ADDRESS_BITS) - 32'd1);
  localparam logic [7:0] MAX_LEN = 8'(MAX_RECORD_BYTES);

  typedef enum logic [6:0] {
    PH_IDLE   = 7'b0000001,
    PH_SKIP   = 7'b0000010,
    PH_HEADER = 7'b0000100,
    PH_DATA   = 7'b0001000,
    PH_TAIL   = 7'b0010000,
    PH_DONE   = 7'b0100000,
    PH_ERROR  = 7'b1000000
  } phase_t;

  phase_t               phase_r, phase_nxt;
  logic [2:0]           pos_r, pos_nxt;
  logic [3:0]           hi_r, hi_nxt;
  logic [LEN_W-1:0]     len_r, len_nxt;
  logic [WADDR_W-1:0]   base_r, base_nxt;
  logic [LEN_W-1:0]     idx_r, idx_nxt;
  logic [FLASH_W-1:0]   flash_r;

  logic                 res_fire;
  result_t              res;
  logic [7:0]           byte_val;
  logic [WADDR_W-1:0]   start_addr;
  logic [SUM_W-1:0]     data_addr;
  char_class_t          ch;

  // result queue
  result_t              rq_r [2];
  logic                 rq_wr_r, rq_rd_r;
  logic [1:0]           rq_count_r, rq_count_nxt;
  logic                 rq_pop;

  assign rq_pop     = out_pop && (rq_count_r != 2'd0);
  assign out_empty  = (rq_count_r == 2'd0);
  assign out_result = rq_r[rq_rd_r];

  // take a character whenever one result can be stored
  assign front_take = front_out.valid && ((rq_count_r != 2'd2) || rq_pop);
  assign ch         = front_out.item;
  assign byte_val   = {hi_r, ch.nibble};
  assign start_addr = {base_r[15:8], byte_val} & ADDR_MASK;
  assign data_addr  = SUM_W'(base_r) + SUM_W'(idx_r);

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    hi_nxt    = hi_r;
    len_nxt   = len_r;
    base_nxt  = base_r;
    idx_nxt   = idx_r;
    res_fire  = 1'b0;
    res.kind          = KIND_WRITE;
    res.write_address = '0;
    res.write_data    = '0;
    if (front_take && (phase_r != PH_DONE) && (phase_r != PH_ERROR)) begin
      if (ch.is_newline) begin
        phase_nxt = PH_IDLE;
      end else begin
        unique case (phase_r)
          PH_IDLE: begin
            if (ch.is_colon) begin
              phase_nxt = PH_HEADER;
              pos_nxt   = 3'd0;
            end else begin
              phase_nxt = PH_SKIP;
            end
          end
          PH_HEADER: begin
            if (!pos_r[0]) begin
              hi_nxt  = ch.nibble;
              pos_nxt = pos_r + 3'd1;
            end else begin
              unique case (pos_r[2:1])
                2'd0: begin
                  if (byte_val > MAX_LEN) begin
                    phase_nxt = PH_ERROR;
                    res_fire  = 1'b1;
                    res.kind  = KIND_TOO_LONG;
                  end else begin
                    len_nxt = byte_val[LEN_W-1:0];
                    pos_nxt = pos_r + 3'd1;
                  end
                end
                2'd1: begin
                  base_nxt = {byte_val, 8'h00};
                  pos_nxt  = pos_r + 3'd1;
                end
                2'd2: begin
                  base_nxt = start_addr;
                  if ({1'b0, start_addr} >= flash_r) begin
                    phase_nxt         = PH_ERROR;
                    res_fire          = 1'b1;
                    res.kind          = KIND_OUT_RANGE;
                    res.write_address = start_addr;
                  end else begin
                    pos_nxt = pos_r + 3'd1;
                  end
                end
                default: begin
                  if (byte_val == TYPE_EOF) begin
                    phase_nxt         = PH_DONE;
                    res_fire          = 1'b1;
                    res.kind          = KIND_END;
                    res.write_address = base_r;
                  end else begin
                    idx_nxt   = '0;
                    pos_nxt   = 3'd0;
                    phase_nxt = (len_r == '0) ? PH_TAIL : PH_DATA;
                  end
                end
              endcase
            end
          end
          PH_DATA: begin
            if (!pos_r[0]) begin
              hi_nxt  = ch.nibble;
              pos_nxt = 3'd1;
            end else begin
              pos_nxt           = 3'd0;
              res_fire          = 1'b1;
              res.write_address = data_addr[WADDR_W-1:0];
              if (data_addr >= flash_r) begin
                phase_nxt = PH_ERROR;
                res.kind  = KIND_OUT_RANGE;
              end else begin
                res.kind       = KIND_WRITE;
                res.write_data = byte_val;
                idx_nxt        = idx_r + LEN_W'(1);
                if ((LEN_W + 1)'(idx_r) + (LEN_W + 1)'(1) >= {1'b0, len_r}) begin
                  phase_nxt = PH_TAIL;
                end
              end
            end
          end
          default: begin
            // skip and tail drop characters up to the newline
          end
        endcase
      end
    end
  end

  always_comb begin
    rq_count_nxt = rq_count_r;
    if (res_fire && !rq_pop) begin
      rq_count_nxt = rq_count_r + 2'd1;
    end else if (rq_pop && !res_fire) begin
      rq_count_nxt = rq_count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      pos_r      <= '0;
      hi_r       <= '0;
      len_r      <= '0;
      base_r     <= '0;
      idx_r      <= '0;
      flash_r    <= FLASH_RESET;
      rq_wr_r    <= 1'b0;
      rq_rd_r    <= 1'b0;
      rq_count_r <= 2'd0;
    end else begin
      phase_r    <= phase_nxt;
      pos_r      <= pos_nxt;
      hi_r       <= hi_nxt;
      len_r      <= len_nxt;
      base_r     <= base_nxt;
      idx_r      <= idx_nxt;
      rq_count_r <= rq_count_nxt;
      if (cfg_valid) begin
        flash_r <= cfg_flash_bytes;
      end
      if (res_fire) begin
        rq_wr_r <= ~rq_wr_r;
      end
      if (rq_pop) begin
        rq_rd_r <= ~rq_rd_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_fire) begin
      rq_r[rq_wr_r] <= res;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/intel_hex_record_parser.sv =====
`default_nettype none
// Intel HEX record parser. Push one text character per cycle; the block
// sustains one character per clock while in_full is low, since each
// character needs a single state update in the back-end parser. A
// character is classified (newline, colon, hex nibble) by the front end
// and queued in a two-entry buffer; the back end then advances the record
// state machine and drops any result into a two-entry result queue that
// drives out_empty. Each character yields zero or one result:
// a data write, an end-of-file marker, a record-too-long error or an
// address-out-of-range error. After an end record or any error the parser
// goes quiet and swallows every further character until reset. The flash
// size register resets to 65536 and is written through cfg_valid/cfg_ready
// (always ready); write it only while no beat is in flight.
module intel_hex_record_parser
  import ihex_pkg::*;
#(
  parameter int MAX_RECORD_BYTES = 16,
  parameter int ADDRESS_BITS     = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // configuration channel
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [FLASH_W-1:0] cfg_flash_bytes,
  // character input queue
  input  wire logic               in_push,
  output logic                    in_full,
  input  wire logic [CHAR_W-1:0]  in_text_char,
  // result output queue
  output logic                    out_empty,
  input  wire logic               out_pop,
  output logic [KIND_W-1:0]       out_kind,
  output logic [WADDR_W-1:0]      out_write_address,
  output logic [WDATA_W-1:0]      out_write_data
);

  front_out_t front_out;
  logic       front_take;
  result_t    out_result;

  // register writes go straight into the flash size register, so never stall them
  assign cfg_ready = 1'b1;

  ihex_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_text_char (in_text_char),
    .front_out    (front_out),
    .front_take   (front_take)
  );

  ihex_back #(
    .MAX_RECORD_BYTES (MAX_RECORD_BYTES),
    .ADDRESS_BITS     (ADDRESS_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_flash_bytes (cfg_flash_bytes),
    .front_out       (front_out),
    .front_take      (front_take),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_result      (out_result)
  );

  // unpack the oldest waiting result beat
  assign out_kind          = out_result.kind;
  assign out_write_address = out_result.write_address;
  assign out_write_data    = out_result.write_data;

endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import ihex_pkg::*;

  localparam int MAX_RECORD_LEN = 16;
  localparam int QUIET_LIMIT    = 3000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int HOLD_OFF       = 300;
  localparam int TX_SIDE        = 0;
  localparam int RX_SIDE        = 1;

  // line-level state of the parser as the predictor tracks it
  typedef enum logic [2:0] {
    LINE_IDLE,
    LINE_SKIP,
    REC_HEADER,
    REC_DATA,
    REC_TAIL,
    PARSE_DONE,
    PARSE_HALT
  } parse_phase_t;

  // how the one allowed sticky stop is reached at the end of the run
  typedef enum int {
    STOP_END_RECORD,
    STOP_LENGTH_OVER,
    STOP_START_PAST,
    STOP_DATA_PAST,
    STOP_NO_FLASH
  } stop_case_t;

  logic               clk;
  logic               rst_n             = 1'b0;
  logic               cfg_valid         = 1'b0;
  logic               cfg_ready;
  logic [FLASH_W-1:0] cfg_flash_bytes   = '0;
  logic               in_push           = 1'b0;
  logic               in_full;
  logic [CHAR_W-1:0]  in_text_char      = '0;
  logic               out_empty;
  logic               out_pop           = 1'b0;
  logic [KIND_W-1:0]  out_kind;
  logic [WADDR_W-1:0] out_write_address;
  logic [WDATA_W-1:0] out_write_data;

  intel_hex_record_parser u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_flash_bytes   (cfg_flash_bytes),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_text_char      (in_text_char),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_kind          (out_kind),
    .out_write_address (out_write_address),
    .out_write_data    (out_write_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor: its own copy of the parser state and of the flash size register
  // ---------------------------------------------------------------------------
  parse_phase_t       parse_phase  = LINE_IDLE;
  logic [5:0]         char_pos     = '0;
  logic [3:0]         upper_nibble = '0;
  logic [7:0]         rec_len      = '0;
  logic [15:0]        rec_base     = '0;
  logic [4:0]         data_idx     = '0;
  logic [FLASH_W-1:0] flash_limit  = FLASH_RESET;

  result_t predicted_results[$];

  // Hex letters in either case give 10-15; every other character keeps its
  // low four bits, which is the same as subtracting '0'.
  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f"))
      return c[3:0] + 4'd9;
    return c[3:0];
  endfunction

  function automatic void predict(input kind_t k, input logic [15:0] a, input logic [7:0] d);
    result_t r;
    r.kind          = k;
    r.write_address = a;
    r.write_data    = d;
    predicted_results.push_back(r);
  endfunction

  // Advance the record state by one character and queue whatever it yields.
  function automatic void decode_char(input logic [7:0] c);
    logic [3:0]  nib;
    logic [7:0]  val;
    logic [16:0] addr;
    // after an end record or any error everything is swallowed
    if (parse_phase == PARSE_DONE || parse_phase == PARSE_HALT)
      return;
    if (c == CHAR_NEWLINE) begin
      parse_phase = LINE_IDLE;
      return;
    end
    nib = nibble_of(c);
    val = {upper_nibble, nib};
    case (parse_phase)
      LINE_IDLE: begin
        if (c == CHAR_COLON) begin
          parse_phase = REC_HEADER;
          char_pos    = '0;
        end else begin
          parse_phase = LINE_SKIP;
        end
      end
      REC_HEADER: begin
        if (!char_pos[0]) begin
          upper_nibble = nib;
          char_pos++;
          return;
        end
        // odd position closes a pair: length, address high, address low, type
        case (char_pos)
          6'd1: begin
            rec_len = val;
            if (rec_len > MAX_RECORD_LEN) begin
              parse_phase = PARSE_HALT;
              predict(KIND_TOO_LONG, 16'd0, 8'd0);
              return;
            end
          end
          6'd3: rec_base[15:8] = val;
          6'd5: begin
            rec_base[7:0] = val;
            // start address is checked before the type is known
            if ({1'b0, rec_base} >= flash_limit) begin
              parse_phase = PARSE_HALT;
              predict(KIND_OUT_RANGE, rec_base, 8'd0);
              return;
            end
          end
          default: begin
            if (val == TYPE_EOF) begin
              parse_phase = PARSE_DONE;
              predict(KIND_END, rec_base, 8'd0);
            end else begin
              data_idx    = '0;
              char_pos    = '0;
              parse_phase = (rec_len == 0) ? REC_TAIL : REC_DATA;
            end
            return;
          end
        endcase
        char_pos++;
      end
      REC_DATA: begin
        if (!char_pos[0]) begin
          upper_nibble = nib;
          char_pos     = 6'd1;
        end else begin
          char_pos = '0;
          addr     = {1'b0, rec_base} + {12'd0, data_idx};
          // a byte running past the flash end is an error of its own
          if (addr >= flash_limit) begin
            parse_phase = PARSE_HALT;
            predict(KIND_OUT_RANGE, addr[15:0], 8'd0);
          end else begin
            predict(KIND_WRITE, addr[15:0], val);
            data_idx++;
            if (data_idx >= rec_len)
              parse_phase = REC_TAIL;
          end
        end
      end
      default: ;  // skip and tail ignore everything up to the newline
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Idle pattern: each side runs in stretches of no idling, full-range gaps
  // or short gaps, switching mode after every 10 to 60 beats.
  // ---------------------------------------------------------------------------
  int gap_mode[2];
  int gap_left[2];

  function automatic int draw_gap(input int side);
    if (gap_left[side] == 0) begin
      gap_mode[side] = $urandom_range(0, 2);
      gap_left[side] = $urandom_range(10, 60);
    end
    gap_left[side]--;
    case (gap_mode[side])
      0:       return 0;
      1:       return $urandom_range(0, 17);
      default: return $urandom_range(0, 2);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Character driver: drive at the falling edge, hold a beat until it is taken
  // ---------------------------------------------------------------------------
  logic [7:0] hex_text[$];
  bit         in_beat_taken  = 1'b0;
  bit         out_beat_taken = 1'b0;
  bit         rx_hold        = 1'b0;
  int         in_wait        = 0;
  int         out_wait       = 0;
  int         chars_taken    = 0;
  int         error_count    = 0;
  int         results_seen   = 0;

  always @(negedge clk) begin
    if (rst_n) begin
      // a beat still waiting for the parser stays on the port untouched
      if (!in_push || in_beat_taken) begin
        if (in_wait > 0) begin
          in_push <= 1'b0;
          in_wait--;
        end else if (hex_text.size() > 0) begin
          in_text_char <= hex_text.pop_front();
          in_push      <= 1'b1;
          in_wait      = draw_gap(TX_SIDE);
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  // Result receiver: idle a drawn number of cycles after every result beat;
  // the hold-off process can shut it off entirely for a long stretch.
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_beat_taken)
        out_wait = draw_gap(RX_SIDE);
      if (rx_hold) begin
        out_pop <= 1'b0;
      end else if (out_wait > 0) begin
        out_pop <= 1'b0;
        out_wait--;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // Back up the result side once the parser is busy with records, while the
  // sender keeps offering characters, so both queues fill and in_full rises.
  initial begin
    while (chars_taken < 60) @(posedge clk);
    rx_hold = 1'b1;
    repeat (HOLD_OFF) @(posedge clk);
    rx_hold = 1'b0;
  end

  function automatic void note_error(input string msg);
    error_count++;
    if (error_count <= 10)
      $display("ERROR: %s", msg);
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: sample both handshakes at the rising edge. Check the result beat
  // first, so a character taken at the same edge never feeds its own check.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t want;
    in_beat_taken  = 1'b0;
    out_beat_taken = 1'b0;
    if (rst_n) begin
      if (out_pop && !out_empty) begin
        out_beat_taken = 1'b1;
        if (predicted_results.size() == 0) begin
          note_error($sformatf("unexpected result: kind %0d addr %h data %h",
                               out_kind, out_write_address, out_write_data));
        end else begin
          want = predicted_results.pop_front();
          if (out_kind !== want.kind || out_write_address !== want.write_address ||
              out_write_data !== want.write_data)
            note_error($sformatf(
              "result %0d: expected kind %0d addr %h data %h, got kind %0d addr %h data %h",
              results_seen, want.kind, want.write_address, want.write_data,
              out_kind, out_write_address, out_write_data));
        end
        results_seen++;
      end
      if (in_push && !in_full) begin
        in_beat_taken = 1'b1;
        chars_taken++;
        decode_char(in_text_char);
      end
    end
  end

  // Watchdog: count cycles in which no beat moves on any channel.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty) ||
        (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no beat for %0d cycles", QUIET_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus generation: build one line in line_buf, then append it to the
  // character queue, optionally cut short before the newline.
  // ---------------------------------------------------------------------------
  logic [7:0] line_buf[$];
  int         planned_chars = 0;
  int         flash_plan    = 65536;

  function automatic logic [7:0] any_text_char();
    logic [7:0] c;
    do c = 8'($urandom); while (c == CHAR_NEWLINE);
    return c;
  endfunction

  // Mostly plain hex digits in mixed case; now and then any character that
  // decodes to the same nibble.
  function automatic void put_nibble(input logic [3:0] n);
    logic [7:0] c;
    logic [3:0] hi;
    if ($urandom_range(0, 3) != 0) begin
      if (n < 4'd10)
        c = "0" + {4'd0, n};
      else
        c = ($urandom_range(0, 1) ? "A" : "a") + {4'd0, n} - 8'd10;
    end else begin
      do begin
        hi = 4'($urandom);
        c  = {hi, n};
      end while (c == CHAR_NEWLINE || nibble_of(c) != n);
    end
    line_buf.push_back(c);
  endfunction

  function automatic void put_byte(input logic [7:0] b);
    put_nibble(b[7:4]);
    put_nibble(b[3:0]);
  endfunction

  function automatic void flush_line(input int keep);
    for (int i = 0; i < keep && i < line_buf.size(); i++)
      hex_text.push_back(line_buf[i]);
    hex_text.push_back(CHAR_NEWLINE);
    planned_chars += keep + 1;
    line_buf.delete();
  endfunction

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++)
      hex_text.push_back(s[i]);
    planned_chars += s.len();
  endfunction

  function automatic logic [7:0] pick_type();
    logic [7:0] t;
    do t = 8'($urandom); while (t == TYPE_EOF);
    return t;
  endfunction

  // One record: header, data, a checksum pair and maybe some trailing junk.
  // A cut keeps at least the colon and drops the newline in before the data
  // is complete.
  function automatic void gen_record(input int len, input int addr, input logic [7:0] typ,
                                     input bit cut);
    int nbytes;
    line_buf.push_back(CHAR_COLON);
    put_byte(8'(len));
    put_byte(8'(addr >> 8));
    put_byte(8'(addr));
    put_byte(typ);
    nbytes = (len > MAX_RECORD_LEN) ? 2 : len;
    repeat (nbytes) put_byte(8'($urandom));
    put_byte(8'($urandom));
    repeat ($urandom_range(0, 2)) line_buf.push_back(any_text_char());
    if (cut)
      flush_line($urandom_range(1, 8 + 2 * nbytes));
    else
      flush_line(line_buf.size());
  endfunction

  // A record that fits the planned flash size, so no error can come of it.
  function automatic void gen_good_record(input logic [7:0] typ, input bit cut);
    int len_max, len, top, addr;
    len_max = (flash_plan < MAX_RECORD_LEN) ? flash_plan : MAX_RECORD_LEN;
    len     = ($urandom_range(0, 3) == 0) ? len_max : $urandom_range(0, len_max);
    // a zero-length record still needs its start address below the flash end
    top     = flash_plan - ((len > 0) ? len : 1);
    if (top > 65535) top = 65535;
    if (top < 0) top = 0;
    case ($urandom_range(0, 7))
      0:       addr = 0;
      1:       addr = top;
      default: addr = $urandom_range(0, top);
    endcase
    gen_record(len, addr, typ, cut);
  endfunction

  // A line that does not start with a colon; the rest may hold anything.
  function automatic void noise_line();
    logic [7:0] c;
    do c = any_text_char(); while (c == CHAR_COLON);
    line_buf.push_back(c);
    repeat ($urandom_range(0, 12)) line_buf.push_back(any_text_char());
    flush_line(line_buf.size());
  endfunction

  function automatic void fill_random(input int budget);
    int goal;
    goal = planned_chars + budget;
    while (planned_chars < goal) begin
      case ($urandom_range(0, 19))
        0, 1:    noise_line();
        2:       flush_line(0);
        3, 4:    gen_good_record(pick_type(), 1'b1);
        default: gen_good_record(pick_type(), 1'b0);
      endcase
    end
  endfunction

  // Write the flash size; the parser is idle whenever this is called.
  task automatic write_flash(input int unsigned v);
    @(negedge clk);
    cfg_flash_bytes <= v[16:0];
    cfg_valid       <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    flash_limit = v[16:0];
    flash_plan  = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Drain: wait for every character to go in and every result to come out,
  // then give characters that yield nothing time to leave the pipeline.
  task automatic settle();
    while (!(hex_text.size() == 0 && !in_push && predicted_results.size() == 0))
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // The parser stops for good after an end record or an error, so the run
  // closes with exactly one such stop, picked at random, then a few records
  // that must be swallowed.
  task automatic stop_parse();
    stop_case_t sel;
    int len, lo, hi;
    sel = stop_case_t'($urandom_range(0, 4));
    case (sel)
      STOP_END_RECORD: begin
        write_flash($urandom_range(1, 65536));
        fill_random(120);
        gen_good_record(TYPE_EOF, 1'b0);
      end
      STOP_LENGTH_OVER: begin
        write_flash($urandom_range(1, 65536));
        fill_random(120);
        gen_record($urandom_range(MAX_RECORD_LEN + 1, 255), $urandom_range(0, 65535),
                   pick_type(), 1'b0);
      end
      STOP_START_PAST: begin
        write_flash($urandom_range(1, 65535));
        fill_random(120);
        gen_record($urandom_range(0, MAX_RECORD_LEN), $urandom_range(flash_plan, 65535),
                   pick_type(), 1'b0);
      end
      STOP_DATA_PAST: begin
        // a full size flash makes the byte address carry past 16 bits
        write_flash($urandom_range(0, 1) ? 65536 : $urandom_range(1, 65535));
        fill_random(120);
        len = $urandom_range(2, MAX_RECORD_LEN);
        lo  = flash_plan - len + 1;
        if (lo < 0) lo = 0;
        hi  = flash_plan - 1;
        if (hi > 65535) hi = 65535;
        gen_record(len, $urandom_range(lo, hi), pick_type(), 1'b0);
      end
      default: begin
        write_flash(0);
        gen_record($urandom_range(0, MAX_RECORD_LEN), $urandom_range(0, 65535),
                   pick_type(), 1'b0);
      end
    endcase
    repeat (3) gen_good_record(pick_type(), 1'b0);
    noise_line();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // full size flash, written explicitly
    write_flash(FLASH_RESET);
    // skipped line holding all-ones and all-zeros characters, a one-byte
    // write at the top address with mixed-case digits, a zero-length record
    // with non-hex characters as digits, and a line cut after the length
    hex_text.push_back(8'hFF);
    hex_text.push_back(8'h00);
    hex_text.push_back(CHAR_COLON);
    hex_text.push_back(CHAR_NEWLINE);
    planned_chars += 4;
    push_text(":01ffFFfEa5\n");
    push_text(":000Gw0FF\n");
    push_text(":01\n");
    fill_random(250);
    settle();

    // smallest flash: only address zero is writable
    write_flash(1);
    fill_random(200);
    settle();

    write_flash($urandom_range(2, MAX_RECORD_LEN));
    fill_random(200);
    settle();

    write_flash($urandom_range(MAX_RECORD_LEN + 1, 65535));
    fill_random(250);
    settle();

    // above the address space: byte addresses may wrap past 16 bits
    write_flash($urandom_range(65537, 131071));
    fill_random(250);
    settle();

    write_flash(FLASH_RESET);
    fill_random(250);
    settle();

    stop_parse();
    settle();

    if (error_count == 0 && predicted_results.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ihex_pkg.sv
rtl/ihex_front.sv
rtl/ihex_back.sv
rtl/intel_hex_record_parser.sv
sim/testbench.sv
